// ===== sv/dsit_pkg.sv =====
// shared widths, codes and record type for the date sorted insert table
`default_nettype none
package dsit_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DATE_W  = YEAR_W + MONTH_W + DAY_W;
	localparam int VAL_W   = 32;
	localparam int IDX_W   = 6;
	localparam int ECNT_W  = 7;
	localparam int STATUS_W = 2;
	localparam int DEFAULT_TABLE_DEPTH = 64;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// date packs year, month, day so an unsigned compare orders by date
	typedef struct packed {
		logic [DATE_W-1:0] date;
		logic [VAL_W-1:0]  total;
		logic [VAL_W-1:0]  lines;
	} rec_t;

endpackage
`default_nettype wire

// ===== sv/date_sorted_insert_table_core.sv =====
// top level of the date sorted insert table
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid, in_stall, command, key_*, sum_value,     | into block
//          | line_count, read_index                            |
//  out     | out_valid, out_stall, status, out_year, out_month, | out of block
//          | out_day, out_total, out_lines, entry_count        |
//
// an insert walks down from the top entry, moving each later record up one
// place per cycle through the single write port; an insert into an empty
// table is written at once. reset clears the state, the count and the output
// valid only; the memory needs no clearing. a stalled result holds the block
// once its next result is ready, one transaction may be accepted while a
// result waits.
`default_nettype none
module date_sorted_insert_table_core #(
	parameter int TABLE_DEPTH = dsit_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        command,
	input  wire logic [dsit_pkg::YEAR_W-1:0]  key_year,
	input  wire logic [dsit_pkg::MONTH_W-1:0] key_month,
	input  wire logic [dsit_pkg::DAY_W-1:0]   key_day,
	input  wire logic [dsit_pkg::VAL_W-1:0]   sum_value,
	input  wire logic [dsit_pkg::VAL_W-1:0]   line_count,
	input  wire logic [dsit_pkg::IDX_W-1:0]   read_index,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [dsit_pkg::STATUS_W-1:0]     status,
	output logic [dsit_pkg::YEAR_W-1:0]       out_year,
	output logic [dsit_pkg::MONTH_W-1:0]      out_month,
	output logic [dsit_pkg::DAY_W-1:0]        out_day,
	output logic [dsit_pkg::VAL_W-1:0]        out_total,
	output logic [dsit_pkg::VAL_W-1:0]        out_lines,
	output logic [dsit_pkg::ECNT_W-1:0]       entry_count
);
	import dsit_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int XW = (CW > IDX_W) ? CW : IDX_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SHIFT = 5'b00010,
		S_PLACE = 5'b00100,
		S_RDWT  = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   ptr_q;
	rec_t            key_q;
	status_t         res_status_q;
	rec_t            res_rec_q;
	logic [ECNT_W-1:0] res_count_q;
	logic            out_valid_q;
	status_t         out_status_q;
	rec_t            out_rec_q;
	logic [ECNT_W-1:0] out_count_q;

	logic            accept;
	logic            full;
	logic            in_range;
	logic [XW-1:0]   idx_x;
	logic [XW-1:0]   cnt_x;
	logic            out_free;
	rec_t            new_rec;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	rec_t            mem_wdata;
	logic [AW-1:0]   mem_raddr;
	rec_t            mem_rdata;
	logic            move_up;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CW'(TABLE_DEPTH));
	assign idx_x    = XW'(read_index);
	assign cnt_x    = XW'(count_q);
	assign in_range = (idx_x < cnt_x);
	assign out_free = !out_valid_q || !out_stall;
	assign move_up  = (mem_rdata.date > key_q.date);

	assign new_rec.date  = {key_year, key_month, key_day};
	assign new_rec.total = sum_value;
	assign new_rec.lines = line_count;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q + AW'(1);
		mem_wdata = mem_rdata;
		mem_raddr = ptr_q - AW'(1);
		case (state_q)
			S_IDLE: begin
				if (accept && command == CMD_INSERT && !full) begin
					if (count_q == '0) begin
						mem_we    = 1'b1;
						mem_waddr = '0;
						mem_wdata = new_rec;
					end else begin
						mem_raddr = AW'(count_q - CW'(1));
					end
				end else if (accept && command == CMD_READ) begin
					mem_raddr = idx_x[AW-1:0];
				end
			end
			S_SHIFT: begin
				// later record moves up, else the new one lands above it
				mem_we = 1'b1;
				if (!move_up) begin
					mem_wdata = key_q;
				end
			end
			S_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = key_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	dsit_table_ram #(
		.DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (command == CMD_INSERT) begin
							if (full) begin
								state_q <= S_FIN;
							end else begin
								count_q <= count_q + CW'(1);
								state_q <= (count_q == '0) ? S_FIN : S_SHIFT;
							end
						end else begin
							state_q <= in_range ? S_RDWT : S_FIN;
						end
					end
				end
				S_SHIFT: begin
					if (!move_up) begin
						state_q <= S_FIN;
					end else if (ptr_q == '0) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: state_q <= S_FIN;
				S_RDWT:  state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_q       <= new_rec;
					ptr_q       <= AW'(count_q - CW'(1));
					res_rec_q   <= '0;
					if (command == CMD_INSERT) begin
						res_status_q <= full ? ST_FULL : ST_OK;
						res_count_q  <= full ? ECNT_W'(count_q)
							: ECNT_W'(count_q + CW'(1));
					end else begin
						res_status_q <= in_range ? ST_OK : ST_RANGE;
						res_count_q  <= ECNT_W'(count_q);
					end
				end
			end
			S_SHIFT: begin
				if (move_up && ptr_q != '0) begin
					ptr_q <= ptr_q - AW'(1);
				end
			end
			S_RDWT: res_rec_q <= mem_rdata;
			S_FIN: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_rec_q    <= res_rec_q;
					out_count_q  <= res_count_q;
				end
			end
			default: begin
				ptr_q <= ptr_q;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign out_year    = out_rec_q.date[DATE_W-1 -: YEAR_W];
	assign out_month   = out_rec_q.date[DAY_W +: MONTH_W];
	assign out_day     = out_rec_q.date[DAY_W-1:0];
	assign out_total   = out_rec_q.total;
	assign out_lines   = out_rec_q.lines;
	assign entry_count = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_write_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != S_IDLE) |-> (CW'(mem_waddr) < count_q))
		else $error("memory write outside the stored entries");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_INSERT && !full) |=>
			(count_q == $past(count_q) + CW'(1)))
		else $error("accepted insert did not bump the count");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished result not presented");

endmodule
`default_nettype wire

// ===== sv/dsit_table_ram.sv =====
// record memory: one write port, one read port with registered read data
`default_nettype none
module dsit_table_ram #(
	parameter int DEPTH = dsit_pkg::DEFAULT_TABLE_DEPTH,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic           clk,
	input  wire logic           we,
	input  wire logic [AW-1:0]  waddr,
	input  wire dsit_pkg::rec_t wdata,
	input  wire logic [AW-1:0]  raddr,
	output dsit_pkg::rec_t      rdata
);
	import dsit_pkg::*;

	rec_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== sim/tb_date_sorted_insert_table_core.sv =====
// self-checking testbench for the date sorted insert table core
module tb_date_sorted_insert_table_core;
	timeunit 1ns;
	timeprecision 1ps;

	import dsit_pkg::*;

	localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 150;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AT        = 200;

	typedef struct {
		logic               cmd;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [VAL_W-1:0]   sum;
		logic [VAL_W-1:0]   lines;
		logic [IDX_W-1:0]   idx;
		bit                 drain;
	} txn_t;

	typedef struct {
		status_t            st;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [VAL_W-1:0]   total;
		logic [VAL_W-1:0]   lines;
		logic [ECNT_W-1:0]  count;
	} reply_t;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic                 command     = CMD_INSERT;
	logic [YEAR_W-1:0]    key_year    = '0;
	logic [MONTH_W-1:0]   key_month   = '0;
	logic [DAY_W-1:0]     key_day     = '0;
	logic [VAL_W-1:0]     sum_value   = '0;
	logic [VAL_W-1:0]     line_count  = '0;
	logic [IDX_W-1:0]     read_index  = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b1;
	logic [STATUS_W-1:0]  status;
	logic [YEAR_W-1:0]    out_year;
	logic [MONTH_W-1:0]   out_month;
	logic [DAY_W-1:0]     out_day;
	logic [VAL_W-1:0]     out_total;
	logic [VAL_W-1:0]     out_lines;
	logic [ECNT_W-1:0]    entry_count;

	// mirror of the table contents
	logic [DATE_W-1:0] mirror_date [DEPTH];
	logic [VAL_W-1:0]  mirror_total[DEPTH];
	logic [VAL_W-1:0]  mirror_lines[DEPTH];
	int                mirror_count = 0;

	txn_t   pending_q[$];
	reply_t table_replies_q[$];
	txn_t   cur;
	reply_t want;
	int     n_sent;
	int     n_recv;
	int     errors = 0;
	int     send_gap;
	int     send_calm;
	int     send_roll;
	int     stall_left;
	int     stall_calm;
	int     stall_roll;
	bit     held;
	int     idle_cycles = 0;

	date_sorted_insert_table_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.key_year   (key_year),
		.key_month  (key_month),
		.key_day    (key_day),
		.sum_value  (sum_value),
		.line_count (line_count),
		.read_index (read_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_year   (out_year),
		.out_month  (out_month),
		.out_day    (out_day),
		.out_total  (out_total),
		.out_lines  (out_lines),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// applies one command to the mirror and returns the reply it must produce
	function automatic reply_t predict_table_reply(txn_t t);
		reply_t            r;
		logic [DATE_W-1:0] key;
		logic [DATE_W-1:0] dv;
		int                pos;
		int                j;
		r.st    = ST_OK;
		r.year  = '0;
		r.month = '0;
		r.day   = '0;
		r.total = '0;
		r.lines = '0;
		if (t.cmd == CMD_INSERT) begin
			key = {t.year, t.month, t.day};
			if (mirror_count >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				// stable: new record goes after every equal date
				pos = 0;
				while (pos < mirror_count && mirror_date[pos] <= key)
					pos++;
				for (j = mirror_count; j > pos; j--) begin
					mirror_date[j]  = mirror_date[j-1];
					mirror_total[j] = mirror_total[j-1];
					mirror_lines[j] = mirror_lines[j-1];
				end
				mirror_date[pos]  = key;
				mirror_total[pos] = t.sum;
				mirror_lines[pos] = t.lines;
				mirror_count++;
			end
		end else begin
			if (int'(t.idx) >= mirror_count) begin
				r.st = ST_RANGE;
			end else begin
				dv      = mirror_date[t.idx];
				r.year  = dv[DATE_W-1 -: YEAR_W];
				r.month = dv[DAY_W +: MONTH_W];
				r.day   = dv[DAY_W-1:0];
				r.total = mirror_total[t.idx];
				r.lines = mirror_lines[t.idx];
			end
		end
		r.count = mirror_count[ECNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string what, input logic [31:0] exp_v,
			input logic [31:0] got);
		if (got !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, got);
			errors++;
		end
	endtask

	task automatic add_txn(input logic cmd, input int y, input int m, input int d,
			input logic [31:0] s, input logic [31:0] l, input int idx, input bit drain);
		txn_t t;
		t.cmd   = cmd;
		t.year  = YEAR_W'(y);
		t.month = MONTH_W'(m);
		t.day   = DAY_W'(d);
		t.sum   = s;
		t.lines = l;
		t.idx   = IDX_W'(idx);
		t.drain = drain;
		pending_q.insert(pending_q.size(), t);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			n_sent    <= 0;
			send_gap  <= 0;
			send_calm <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				table_replies_q.insert(table_replies_q.size(), predict_table_reply(cur));
				n_sent <= n_sent + 1;
			end
			if (in_valid && in_stall) begin
				// stalled transaction stays put
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_q.size() > 0 && !(pending_q[0].drain &&
					((in_valid && !in_stall) || n_sent != n_recv))) begin
				cur = pending_q.pop_front();
				in_valid   <= 1'b1;
				command    <= cur.cmd;
				key_year   <= cur.year;
				key_month  <= cur.month;
				key_day    <= cur.day;
				sum_value  <= cur.sum;
				line_count <= cur.lines;
				read_index <= cur.idx;
				send_roll = $urandom_range(0, 99);
				if (send_calm > 0) begin
					send_calm <= send_calm - 1;
					send_gap  <= 0;
				end else if (send_roll < 5) begin
					send_calm <= $urandom_range(10, 40);
					send_gap  <= 0;
				end else if (send_roll < 45) begin
					send_gap <= $urandom_range(1, 4);
				end else if (send_roll < 55) begin
					send_gap <= $urandom_range(5, 80);
				end else begin
					send_gap <= 0;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, with one long hold-off to fill the block
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b1;
			stall_left <= 0;
			stall_calm <= 0;
			held       <= 1'b0;
		end else if (!held && n_recv >= HOLD_AT) begin
			out_stall  <= 1'b1;
			stall_left <= HOLD_CYCLES;
			held       <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_calm > 0) begin
				out_stall  <= 1'b0;
				stall_calm <= stall_calm - 1;
			end else if (stall_roll < 3) begin
				out_stall  <= 1'b0;
				stall_calm <= $urandom_range(20, 100);
			end else if (stall_roll < 25) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 3);
			end else if (stall_roll < 28) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(10, 60);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_recv <= 0;
		end else if (out_valid && !out_stall) begin
			n_recv <= n_recv + 1;
			if (table_replies_q.size() == 0) begin
				$display("%0t: result transaction with nothing expected, actual status %0d",
					$time, status);
				errors++;
			end else begin
				want = table_replies_q.pop_front();
				check_field("status", 32'(want.st), 32'(status));
				check_field("out_year", 32'(want.year), 32'(out_year));
				check_field("out_month", 32'(want.month), 32'(out_month));
				check_field("out_day", 32'(want.day), 32'(out_day));
				check_field("out_total", want.total, out_total);
				check_field("out_lines", want.lines, out_lines);
				check_field("entry_count", 32'(want.count), 32'(entry_count));
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_date_sorted_insert_table_core failed");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

	initial begin
		int   i;
		int   guess;
		int   roll;
		bit   is_ins;
		int   y, m, d, idx;

		// directed: empty reads, extreme keys, ties, reads across and past the end
		add_txn(CMD_READ, 0, 0, 0, 0, 0, 0, 0);
		add_txn(CMD_READ, 0, 0, 0, 0, 0, 63, 0);
		add_txn(CMD_INSERT, 2000, 6, 15, 32'hFFFF_FFFF, 32'h0, 0, 0);
		add_txn(CMD_INSERT, 2000, 6, 15, 32'h1, 32'hFFFF_FFFF, 0, 0);
		add_txn(CMD_INSERT, 0, 0, 0, 32'h0, 32'h0, 0, 0);
		add_txn(CMD_INSERT, 16383, 15, 31, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0, 0);
		add_txn(CMD_INSERT, 9999, 12, 31, 32'h8000_0000, 32'h0000_0001, 0, 0);
		add_txn(CMD_INSERT, 2000, 6, 14, 32'h1234_5678, 32'h9ABC_DEF0, 0, 0);
		add_txn(CMD_INSERT, 2000, 6, 15, 32'h3, 32'h3, 0, 0);
		for (i = 0; i < 9; i++)
			add_txn(CMD_READ, 0, 0, 0, 0, 0, i, (i == 0));
		guess = 7;

		for (i = 0; i < 480; i++) begin
			is_ins = (guess < DEPTH) ? ($urandom_range(0, 1) == 1)
				: ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				// narrow pool so equal dates are common
				y = 2020 + $urandom_range(0, 1);
				m = $urandom_range(1, 2);
				d = $urandom_range(1, 3);
			end else if (roll < 85) begin
				y = $urandom_range(1970, 2038);
				m = $urandom_range(1, 12);
				d = $urandom_range(1, 31);
			end else begin
				y = $urandom_range(0, 16383);
				m = $urandom_range(0, 15);
				d = $urandom_range(0, 31);
			end
			if (!is_ins && guess > 0 && $urandom_range(0, 99) < 80)
				idx = $urandom_range(0, guess - 1);
			else
				idx = $urandom_range(0, 63);
			add_txn(is_ins ? CMD_INSERT : CMD_READ, y, m, d, $urandom, $urandom, idx,
				(i == 240) || ($urandom_range(0, 99) == 0));
			if (is_ins && guess < DEPTH) begin
				guess++;
				if (guess == DEPTH) begin
					add_txn(CMD_READ, 0, 0, 0, 0, 0, DEPTH - 1, 0);
					add_txn(CMD_READ, 0, 0, 0, 0, 0, 0, 0);
					add_txn(CMD_INSERT, 0, 0, 0, $urandom, $urandom, 0, 0);
				end
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_q.size() != 0 || in_valid || n_recv != n_sent);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (table_replies_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, table_replies_q.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_date_sorted_insert_table_core passed");
		else
			$display("tb_date_sorted_insert_table_core failed");
		$finish;
	end

endmodule
